### sv/assert_macros.svh
// assertion macros used by the smoothing pass unit rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/casp_pkg.sv
// package with constants for the cave smoothing pass unit
`default_nettype none

package casp_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;
   localparam int MIN_DIM        = 3;

   localparam int DIM_W   = 11;
   localparam int COORD_W = 10;
   localparam int THR_W   = 4;
   localparam int CNT_W   = 4;

   // register indexes on the csr port (byte address 4 * index)
   localparam logic [2:0] REG_GRID_WIDTH     = 3'd0;
   localparam logic [2:0] REG_GRID_HEIGHT    = 3'd1;
   localparam logic [2:0] REG_WALL_THRESHOLD = 3'd2;
   localparam logic [2:0] REG_START_COL      = 3'd3;
   localparam logic [2:0] REG_START_ROW      = 3'd4;
   localparam logic [2:0] REG_EXIT_COL       = 3'd5;
   localparam logic [2:0] REG_EXIT_ROW       = 3'd6;

   localparam logic [DIM_W-1:0]   GRID_WIDTH_RST     = 11'd64;
   localparam logic [DIM_W-1:0]   GRID_HEIGHT_RST    = 11'd64;
   localparam logic [THR_W-1:0]   WALL_THRESHOLD_RST = 4'd5;
   localparam logic [COORD_W-1:0] START_COL_RST      = 10'd1;
   localparam logic [COORD_W-1:0] START_ROW_RST      = 10'd1;
   localparam logic [COORD_W-1:0] EXIT_COL_RST       = 10'd62;
   localparam logic [COORD_W-1:0] EXIT_ROW_RST       = 10'd62;

   // input row tracking saturates once the window has two rows behind it
   localparam logic [1:0] IN_ROW_FIRST  = 2'd0;
   localparam logic [1:0] IN_ROW_SECOND = 2'd1;
   localparam logic [1:0] IN_ROW_FULL   = 2'd2;

   localparam int WIN_W      = 9;
   localparam int WIN_CENTER = 4;
   localparam logic [WIN_W-1:0] WIN_RST = 9'h1FF;

   // result queue
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

endpackage

`default_nettype wire

### sv/cave_automaton_smoothing_pass_unit.sv
// cave smoothing pass: line-buffered 3x3 automaton step over a raster cell stream
//
//   channel | direction | handshake              | payload
//   req     | in        | req_tvalid/req_tready  | tdata[0] cell_wall, tuser cmd
//   rsp     | out       | rsp_tvalid/rsp_tready  | tdata[0] next_wall, tlast frame_last
//   csr     | in        | psel/penable/pwrite    | 7 registers at byte address 4*i
//
// one item per cycle while req_tready is high: accept and line buffer read, then window update, rule and write-back
// a result passes the stage 1 registers and the result queue before it reaches rsp
// after reset a clearing pass over all MAX_WIDTH columns fills both line buffers with walls
// req_tready is low during that pass and while queued results plus any item in stage 1 number three or more
`default_nettype none
`include "assert_macros.svh"

module cave_automaton_smoothing_pass_unit #(
   parameter int MAX_WIDTH  = casp_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = casp_pkg::MAX_HEIGHT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,     // [0] cell_wall
   input  logic        req_tuser,     // [0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,     // [0] next_wall
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int DW0     = casp_pkg::DIM_W;
   localparam int DW1     = $clog2(MAX_WIDTH + 1);
   localparam int DW2     = $clog2(MAX_HEIGHT + 1);
   localparam int DW01    = (DW0 > DW1) ? DW0 : DW1;
   localparam int EXT_W   = (DW01 > DW2) ? DW01 : DW2;
   localparam int PW0     = (COL_W > ROW_W) ? COL_W : ROW_W;
   localparam int POS_W   = (PW0 > casp_pkg::COORD_W) ? PW0 : casp_pkg::COORD_W;
   localparam int DIM_W   = casp_pkg::DIM_W;
   localparam int CRD_W   = casp_pkg::COORD_W;
   localparam int THR_W   = casp_pkg::THR_W;
   localparam int CNT_W   = casp_pkg::CNT_W;
   localparam int WIN_W   = casp_pkg::WIN_W;
   localparam int PTR_W   = casp_pkg::RSP_PTR_W;
   localparam int RCW     = casp_pkg::RSP_CNT_W;

   // configuration registers
   logic [DIM_W-1:0] grid_width_ff, grid_height_ff;
   logic [THR_W-1:0] wall_threshold_ff;
   logic [CRD_W-1:0] start_col_ff, start_row_ff, exit_col_ff, exit_row_ff;
   logic             csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff     <= casp_pkg::GRID_WIDTH_RST;
         grid_height_ff    <= casp_pkg::GRID_HEIGHT_RST;
         wall_threshold_ff <= casp_pkg::WALL_THRESHOLD_RST;
         start_col_ff      <= casp_pkg::START_COL_RST;
         start_row_ff      <= casp_pkg::START_ROW_RST;
         exit_col_ff       <= casp_pkg::EXIT_COL_RST;
         exit_row_ff       <= casp_pkg::EXIT_ROW_RST;
      end else if (csr_write) begin
         case (csr_paddr[4:2])
            casp_pkg::REG_GRID_WIDTH:     grid_width_ff     <= csr_pwdata[DIM_W-1:0];
            casp_pkg::REG_GRID_HEIGHT:    grid_height_ff    <= csr_pwdata[DIM_W-1:0];
            casp_pkg::REG_WALL_THRESHOLD: wall_threshold_ff <= csr_pwdata[THR_W-1:0];
            casp_pkg::REG_START_COL:      start_col_ff      <= csr_pwdata[CRD_W-1:0];
            casp_pkg::REG_START_ROW:      start_row_ff      <= csr_pwdata[CRD_W-1:0];
            casp_pkg::REG_EXIT_COL:       exit_col_ff       <= csr_pwdata[CRD_W-1:0];
            casp_pkg::REG_EXIT_ROW:       exit_row_ff       <= csr_pwdata[CRD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         casp_pkg::REG_GRID_WIDTH:     csr_prdata = 32'(grid_width_ff);
         casp_pkg::REG_GRID_HEIGHT:    csr_prdata = 32'(grid_height_ff);
         casp_pkg::REG_WALL_THRESHOLD: csr_prdata = 32'(wall_threshold_ff);
         casp_pkg::REG_START_COL:      csr_prdata = 32'(start_col_ff);
         casp_pkg::REG_START_ROW:      csr_prdata = 32'(start_row_ff);
         casp_pkg::REG_EXIT_COL:       csr_prdata = 32'(exit_col_ff);
         casp_pkg::REG_EXIT_ROW:       csr_prdata = 32'(exit_row_ff);
         default:                      csr_prdata = '0;
      endcase
   end

   // clamped grid size
   logic [EXT_W-1:0] gw_ext, gh_ext, w_eff, h_eff;

   always_comb begin
      gw_ext = EXT_W'(grid_width_ff);
      gh_ext = EXT_W'(grid_height_ff);
      if (gw_ext < EXT_W'(casp_pkg::MIN_DIM)) begin
         w_eff = EXT_W'(casp_pkg::MIN_DIM);
      end else if (gw_ext > EXT_W'(MAX_WIDTH)) begin
         w_eff = EXT_W'(MAX_WIDTH);
      end else begin
         w_eff = gw_ext;
      end
      if (gh_ext < EXT_W'(casp_pkg::MIN_DIM)) begin
         h_eff = EXT_W'(casp_pkg::MIN_DIM);
      end else if (gh_ext > EXT_W'(MAX_HEIGHT)) begin
         h_eff = EXT_W'(MAX_HEIGHT);
      end else begin
         h_eff = gh_ext;
      end
   end

   // line buffer clearing pass after reset
   logic             clear_active_ff;
   logic [COL_W-1:0] clear_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_active_ff <= 1'b1;
         clear_addr_ff   <= '0;
      end else if (clear_active_ff) begin
         clear_addr_ff <= clear_addr_ff + COL_W'(1);
         if (clear_addr_ff == COL_W'(MAX_WIDTH - 1)) begin
            clear_active_ff <= 1'b0;
         end
      end
   end

   // stage 0: accept, position counters, line buffer read
   logic             req_accept;
   logic             cell_v;
   logic             emit0, border0, last0, free0;
   logic [COL_W-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [1:0]       in_row_ff, in_row_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;
   logic [EXT_W-1:0] in_col_p1, out_col_p1, out_row_p1;
   logic             in_wrap, out_col_wrap, out_row_end;
   logic [POS_W-1:0] oc_pos, or_pos;

   logic             s1_valid_ff;
   logic             s1_v_ff, s1_emit_ff, s1_border_ff, s1_last_ff, s1_free_ff;
   logic [COL_W-1:0] s1_addr_ff;
   logic [RCW-1:0]   rsp_count_ff;

   assign req_tready = !clear_active_ff &&
                       ((rsp_count_ff + RCW'(s1_valid_ff)) < RCW'(casp_pkg::RSP_DEPTH - 1));
   assign req_accept = req_tvalid && req_tready;
   assign cell_v     = req_tuser || req_tdata[0];

   always_comb begin
      in_col_p1    = EXT_W'(in_col_ff) + EXT_W'(1);
      out_col_p1   = EXT_W'(out_col_ff) + EXT_W'(1);
      out_row_p1   = EXT_W'(out_row_ff) + EXT_W'(1);
      in_wrap      = in_col_p1 >= w_eff;
      out_col_wrap = out_col_p1 >= w_eff;
      out_row_end  = out_row_p1 >= h_eff;
      oc_pos       = POS_W'(out_col_ff);
      or_pos       = POS_W'(out_row_ff);

      emit0   = (in_row_ff == casp_pkg::IN_ROW_FULL) ||
                (in_row_ff == casp_pkg::IN_ROW_SECOND && in_col_ff != '0);
      border0 = out_col_ff == '0 || out_row_ff == '0 || out_col_wrap || out_row_end;
      last0   = out_col_wrap && out_row_end;
      free0   = (oc_pos == POS_W'(start_col_ff) && or_pos == POS_W'(start_row_ff)) ||
                (oc_pos == POS_W'(exit_col_ff) && or_pos == POS_W'(exit_row_ff));

      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (req_accept) begin
         if (in_wrap) begin
            in_col_in = '0;
            if (in_row_ff != casp_pkg::IN_ROW_FULL) begin
               in_row_in = in_row_ff + 2'd1;
            end
         end else begin
            in_col_in = in_col_p1[COL_W-1:0];
         end
         if (emit0) begin
            if (last0) begin
               in_col_in  = '0;
               in_row_in  = casp_pkg::IN_ROW_FIRST;
               out_col_in = '0;
               out_row_in = '0;
            end else if (out_col_wrap) begin
               out_col_in = '0;
               out_row_in = out_row_p1[ROW_W-1:0];
            end else begin
               out_col_in = out_col_p1[COL_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= casp_pkg::IN_ROW_FIRST;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   // line buffers
   logic             row_older_mem [MAX_WIDTH];
   logic             row_newer_mem [MAX_WIDTH];
   logic             older_rd_ff, newer_rd_ff;
   logic             mem_we, mem_wolder, mem_wnewer;
   logic [COL_W-1:0] mem_waddr;

   always_comb begin
      if (clear_active_ff) begin
         mem_we     = 1'b1;
         mem_waddr  = clear_addr_ff;
         mem_wolder = 1'b1;
         mem_wnewer = 1'b1;
      end else begin
         mem_we     = s1_valid_ff;
         mem_waddr  = s1_addr_ff;
         mem_wolder = newer_rd_ff;
         mem_wnewer = s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         row_older_mem[mem_waddr] <= mem_wolder;
         row_newer_mem[mem_waddr] <= mem_wnewer;
      end
      if (req_accept) begin
         // write-back to the column being read is passed straight through
         if (mem_we && mem_waddr == in_col_ff) begin
            older_rd_ff <= mem_wolder;
            newer_rd_ff <= mem_wnewer;
         end else begin
            older_rd_ff <= row_older_mem[in_col_ff];
            newer_rd_ff <= row_newer_mem[in_col_ff];
         end
      end
   end

   // stage 1: window shift, neighbor rule, write-back
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_v_ff      <= cell_v;
         s1_emit_ff   <= emit0;
         s1_border_ff <= border0;
         s1_last_ff   <= last0;
         s1_free_ff   <= free0;
         s1_addr_ff   <= in_col_ff;
      end
   end

   logic [WIN_W-1:0] window_ff, window_in;
   logic [CNT_W-1:0] wall_count;
   logic             next_wall1;

   always_comb begin
      window_in  = {s1_v_ff, newer_rd_ff, older_rd_ff, window_ff[WIN_W-1:3]};
      wall_count = '0;
      for (int i = 0; i < WIN_W; i++) begin
         if (i != casp_pkg::WIN_CENTER) begin
            wall_count = wall_count + CNT_W'(window_in[i]);
         end
      end
      if (s1_free_ff) begin
         next_wall1 = 1'b0;
      end else if (s1_border_ff) begin
         next_wall1 = 1'b1;
      end else begin
         next_wall1 = wall_count >= wall_threshold_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= casp_pkg::WIN_RST;
      end else if (s1_valid_ff) begin
         window_ff <= window_in;
      end
   end

   // result queue
   logic [1:0]       rsp_mem_ff [casp_pkg::RSP_DEPTH];
   logic [PTR_W-1:0] rsp_wr_ptr_ff, rsp_rd_ptr_ff;
   logic             rsp_push, rsp_pop;

   assign rsp_push   = s1_valid_ff && s1_emit_ff;
   assign rsp_tvalid = rsp_count_ff != '0;
   assign rsp_pop    = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = {7'b0, rsp_mem_ff[rsp_rd_ptr_ff][0]};
   assign rsp_tlast  = rsp_mem_ff[rsp_rd_ptr_ff][1];

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         rsp_mem_ff[rsp_wr_ptr_ff] <= {s1_last_ff, next_wall1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_wr_ptr_ff <= '0;
         rsp_rd_ptr_ff <= '0;
         rsp_count_ff  <= '0;
      end else begin
         if (rsp_push) begin
            rsp_wr_ptr_ff <= rsp_wr_ptr_ff + PTR_W'(1);
         end
         if (rsp_pop) begin
            rsp_rd_ptr_ff <= rsp_rd_ptr_ff + PTR_W'(1);
         end
         rsp_count_ff <= RCW'(rsp_count_ff + RCW'(rsp_push) - RCW'(rsp_pop));
      end
   end

   `ASSERT_IMPLIES(a_rsp_room, rsp_push, rsp_count_ff < RCW'(casp_pkg::RSP_DEPTH), "result queue overflow")
   `ASSERT_ALWAYS(a_no_ready_while_clearing, !(clear_active_ff && req_tready), "ready in clear")
   `ASSERT_NEXT(a_frame_restart, req_accept && emit0 && last0, in_col_ff == '0 && in_row_ff == casp_pkg::IN_ROW_FIRST && out_col_ff == '0 && out_row_ff == '0, "counters not cleared after last cell")
   `ASSERT_ALWAYS(a_idle_while_clearing, !(clear_active_ff && s1_valid_ff), "item in flight during clearing pass")

endmodule

`default_nettype wire

### tb/cave_automaton_smoothing_pass_unit_tb.sv
// testbench for the cave smoothing pass unit: raster frames checked against a line-buffer predictor
`default_nettype none

module cave_automaton_smoothing_pass_unit_tb;

   localparam int GRID_MAX_W    = casp_pkg::MAX_WIDTH_DEF;
   localparam int GRID_MAX_H    = casp_pkg::MAX_HEIGHT_DEF;
   localparam int ROW_SATURATE  = 2047;
   localparam int RANDOM_ITEMS  = 850;
   localparam int LONG_HOLD     = 400;
   localparam int SETTLE_CYCLES = 8;
   localparam int QUIET_LIMIT   = 8000;
   localparam int REPORT_LIMIT  = 10;

   localparam logic CMD_CELL  = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   typedef struct packed {
      logic cmd;
      logic cell_wall;
   } cell_item_type;

   typedef struct packed {
      logic next_wall;
      logic frame_last;
   } smoothed_cell_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_HALF,
      READY_SPARSE,
      READY_PERIODIC
   } ready_mode_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = '0;   // [0] cell_wall
   logic        req_tuser   = 1'b0; // [0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [7:0]  rsp_tdata;          // [0] next_wall
   logic        rsp_tlast;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [4:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   cave_automaton_smoothing_pass_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   // shadow configuration
   logic [casp_pkg::DIM_W-1:0]   cfg_width     = casp_pkg::GRID_WIDTH_RST;
   logic [casp_pkg::DIM_W-1:0]   cfg_height    = casp_pkg::GRID_HEIGHT_RST;
   logic [casp_pkg::THR_W-1:0]   cfg_threshold = casp_pkg::WALL_THRESHOLD_RST;
   logic [casp_pkg::COORD_W-1:0] cfg_start_col = casp_pkg::START_COL_RST;
   logic [casp_pkg::COORD_W-1:0] cfg_start_row = casp_pkg::START_ROW_RST;
   logic [casp_pkg::COORD_W-1:0] cfg_exit_col  = casp_pkg::EXIT_COL_RST;
   logic [casp_pkg::COORD_W-1:0] cfg_exit_row  = casp_pkg::EXIT_ROW_RST;

   // predictor state
   logic                       line_older [GRID_MAX_W];
   logic                       line_newer [GRID_MAX_W];
   logic [casp_pkg::WIN_W-1:0] stencil = casp_pkg::WIN_RST;
   int unsigned                in_col = 0, in_row = 0, out_col = 0, out_row = 0;

   cell_item_type     cell_queue[$];
   smoothed_cell_type expected_cells[$];

   int unsigned mismatch_count = 0;
   int unsigned results_seen   = 0;
   int unsigned quiet_cycles   = 0;
   logic        offer_taken    = 1'b0;

   int unsigned    burst_left = 0, gap_left = 0;
   int unsigned    hold_left = 0, mode_left = 0, ready_tick = 0;
   ready_mode_type rsp_mode = READY_ALWAYS;
   logic           hold_off_armed = 1'b0;
   logic           hold_off_done  = 1'b0;

   function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
      if (v < casp_pkg::MIN_DIM) return casp_pkg::MIN_DIM;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void note_mismatch(input string what, input logic [31:0] want,
                                         input logic [31:0] got);
      if (mismatch_count < REPORT_LIMIT)
         $display("mismatch at %0t, result %0d: %s expected %0h got %0h",
                  $realtime, results_seen, what, want, got);
      mismatch_count++;
   endfunction

   // one generation of the cave rule for one accepted cell transaction
   function automatic void smooth_step(input logic cmd, input logic wall_in);
      int unsigned w, h, col, nbrs;
      logic v, top, mid, emit, border, last, nxt;
      w = clamp_dim(cfg_width, GRID_MAX_W);
      h = clamp_dim(cfg_height, GRID_MAX_H);
      v = (cmd == CMD_DRAIN) ? 1'b1 : wall_in;
      col = (in_col < GRID_MAX_W) ? in_col : GRID_MAX_W - 1;
      top = line_older[col];
      mid = line_newer[col];
      emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
      line_older[col] = mid;
      line_newer[col] = v;
      stencil = {v, mid, top, stencil[casp_pkg::WIN_W-1:3]};
      if (in_col + 1 >= w) begin
         in_col = 0;
         if (in_row < ROW_SATURATE) in_row++;
      end else begin
         in_col++;
      end
      if (emit) begin
         border = out_col == 0 || out_row == 0 || out_col + 1 >= w || out_row + 1 >= h;
         last = (out_row + 1 >= h) && (out_col + 1 >= w);
         nbrs = $countones(stencil) - stencil[casp_pkg::WIN_CENTER];
         nxt = border ? 1'b1 : (nbrs >= cfg_threshold);
         if ((out_col == cfg_start_col && out_row == cfg_start_row) ||
             (out_col == cfg_exit_col && out_row == cfg_exit_row))
            nxt = 1'b0;
         expected_cells.push_back('{next_wall: nxt, frame_last: last});
         if (last) begin
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
         end else if (out_col + 1 >= w) begin
            out_col = 0;
            out_row++;
         end else begin
            out_col++;
         end
      end
   endfunction

   function automatic logic [31:0] reg_mask(input logic [2:0] idx);
      case (idx)
         casp_pkg::REG_GRID_WIDTH,
         casp_pkg::REG_GRID_HEIGHT:    return (32'd1 << casp_pkg::DIM_W) - 1;
         casp_pkg::REG_WALL_THRESHOLD: return (32'd1 << casp_pkg::THR_W) - 1;
         default:                      return (32'd1 << casp_pkg::COORD_W) - 1;
      endcase
   endfunction

   function automatic logic [31:0] reg_reset_value(input logic [2:0] idx);
      case (idx)
         casp_pkg::REG_GRID_WIDTH:     return casp_pkg::GRID_WIDTH_RST;
         casp_pkg::REG_GRID_HEIGHT:    return casp_pkg::GRID_HEIGHT_RST;
         casp_pkg::REG_WALL_THRESHOLD: return casp_pkg::WALL_THRESHOLD_RST;
         casp_pkg::REG_START_COL:      return casp_pkg::START_COL_RST;
         casp_pkg::REG_START_ROW:      return casp_pkg::START_ROW_RST;
         casp_pkg::REG_EXIT_COL:       return casp_pkg::EXIT_COL_RST;
         default:                      return casp_pkg::EXIT_ROW_RST;
      endcase
   endfunction

   task automatic csr_access(input logic [2:0] idx, input logic wr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // write a register, keep the shadow copy, then read it back
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      logic [31:0] mask, rd;
      mask = reg_mask(idx);
      csr_access(idx, 1'b1, (value & mask) | ($urandom & ~mask), rd);
      case (idx)
         casp_pkg::REG_GRID_WIDTH:     cfg_width     = value[casp_pkg::DIM_W-1:0];
         casp_pkg::REG_GRID_HEIGHT:    cfg_height    = value[casp_pkg::DIM_W-1:0];
         casp_pkg::REG_WALL_THRESHOLD: cfg_threshold = value[casp_pkg::THR_W-1:0];
         casp_pkg::REG_START_COL:      cfg_start_col = value[casp_pkg::COORD_W-1:0];
         casp_pkg::REG_START_ROW:      cfg_start_row = value[casp_pkg::COORD_W-1:0];
         casp_pkg::REG_EXIT_COL:       cfg_exit_col  = value[casp_pkg::COORD_W-1:0];
         default:                      cfg_exit_row  = value[casp_pkg::COORD_W-1:0];
      endcase
      csr_access(idx, 1'b0, $urandom, rd);
      if (rd !== (value & mask)) note_mismatch($sformatf("csr read of reg %0d", idx),
                                               value & mask, rd);
   endtask

   task automatic wait_idle();
      while (cell_queue.size() != 0 || expected_cells.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic void push_pattern(input int n, input logic [15:0] cmds,
                                        input logic [15:0] walls);
      for (int i = 0; i < n; i++) cell_queue.push_back('{cmd: cmds[i], cell_wall: walls[i]});
   endfunction

   // one whole frame under the current size; broken frames swap some cells and drains
   function automatic int unsigned push_frame(input logic broken);
      int unsigned w, h, cells, total, density;
      cell_item_type item;
      w = clamp_dim(cfg_width, GRID_MAX_W);
      h = clamp_dim(cfg_height, GRID_MAX_H);
      cells = w * h;
      total = cells + w + 1;
      density = $urandom_range(0, 100);
      for (int i = 0; i < total; i++) begin
         item.cell_wall = ($urandom_range(0, 99) < density);
         if (broken && $urandom_range(0, 7) == 0)
            item.cmd = (i < cells) ? CMD_DRAIN : CMD_CELL;
         else
            item.cmd = (i < cells) ? CMD_CELL : CMD_DRAIN;
         cell_queue.push_back(item);
      end
      return total;
   endfunction

   function automatic int unsigned pick_dim();
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 2);
      return $urandom_range(3, 10);
   endfunction

   function automatic int unsigned pick_coord(input int unsigned dim);
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, 1023);
         1:       return $urandom_range(0, 1) ? 0 : dim - 1;
         default: return $urandom_range(1, dim - 2);
      endcase
   endfunction

   // sender: bursts of random length with gaps, valid held until taken
   always @(negedge clock) begin
      logic offer;
      if (reset) begin
         offer = 1'b0;
      end else if (req_tvalid && !offer_taken) begin
         offer = 1'b1;
      end else if (gap_left != 0) begin
         gap_left--;
         offer = 1'b0;
      end else begin
         offer = 1'b1;
         if (burst_left != 0) begin
            burst_left--;
         end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                     : $urandom_range(0, 16);
            gap_left = $urandom_range(1, 10);
         end
      end
      offer = offer && (cell_queue.size() != 0);
      req_tvalid <= offer;
      if (offer) begin
         req_tdata <= {7'b0, cell_queue[0].cell_wall};
         req_tuser <= cell_queue[0].cmd;
      end else begin
         req_tdata <= $urandom;
         req_tuser <= $urandom;
      end
   end

   // receiver: changing ready patterns plus one long hold-off
   always @(negedge clock) begin
      logic ready;
      if (reset) begin
         ready = 1'b0;
      end else begin
         if (mode_left == 0) begin
            rsp_mode = ready_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         if (hold_left != 0) begin
            hold_left--;
            ready = 1'b0;
         end else if (hold_off_armed && !hold_off_done) begin
            hold_off_done = 1'b1;
            hold_left = LONG_HOLD;
            ready = 1'b0;
         end else begin
            case (rsp_mode)
               READY_ALWAYS: ready = 1'b1;
               READY_HALF:   ready = $urandom_range(0, 1);
               READY_SPARSE: ready = ($urandom_range(0, 3) == 0);
               default:      ready = (ready_tick[1:0] != 2'd3);
            endcase
         end
         ready_tick++;
      end
      rsp_tready <= ready;
   end

   // monitor: check results, predict accepted cells, watchdog
   always @(posedge clock) begin
      smoothed_cell_type want;
      logic busy;
      if (!reset) begin
         busy = 1'b0;
         if (rsp_tvalid && rsp_tready) begin
            busy = 1'b1;
            if (expected_cells.size() == 0) begin
               note_mismatch("unexpected transaction, next_wall", 0, rsp_tdata[0]);
            end else begin
               want = expected_cells.pop_front();
               if (rsp_tdata[0] !== want.next_wall)
                  note_mismatch("next_wall", want.next_wall, rsp_tdata[0]);
               if (rsp_tlast !== want.frame_last)
                  note_mismatch("frame_last", want.frame_last, rsp_tlast);
            end
            results_seen++;
         end
         offer_taken = req_tvalid && req_tready;
         if (offer_taken) begin
            busy = 1'b1;
            smooth_step(req_tuser, req_tdata[0]);
            cell_queue.delete(0);
         end
         if (csr_psel && csr_penable && csr_pready) busy = 1'b1;
         quiet_cycles = busy ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      int unsigned w, h, wc, hc, random_items, frames;
      logic [31:0] rd;
      foreach (line_older[i]) begin
         line_older[i] = 1'b1;
         line_newer[i] = 1'b1;
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = casp_pkg::REG_GRID_WIDTH; i <= casp_pkg::REG_EXIT_ROW; i++) begin
         csr_access(i[2:0], 1'b0, $urandom, rd);
         if (rd !== reg_reset_value(i[2:0]))
            note_mismatch($sformatf("reset value of reg %0d", i), reg_reset_value(i[2:0]), rd);
      end

      // smallest grid via clamping, threshold zero, start off the grid, exit in a corner
      csr_write(casp_pkg::REG_GRID_WIDTH, 0);
      csr_write(casp_pkg::REG_GRID_HEIGHT, 2);
      csr_write(casp_pkg::REG_WALL_THRESHOLD, 0);
      csr_write(casp_pkg::REG_START_COL, 1023);
      csr_write(casp_pkg::REG_START_ROW, 1023);
      csr_write(casp_pkg::REG_EXIT_COL, 0);
      csr_write(casp_pkg::REG_EXIT_ROW, 0);
      push_pattern(13, 16'h1600, 16'h0545);
      wait_idle();

      // threshold above eight, start on the border, drain in place of the center cell
      csr_write(casp_pkg::REG_WALL_THRESHOLD, 9);
      csr_write(casp_pkg::REG_START_COL, 2);
      csr_write(casp_pkg::REG_START_ROW, 0);
      csr_write(casp_pkg::REG_EXIT_COL, 5);
      csr_write(casp_pkg::REG_EXIT_ROW, 5);
      push_pattern(13, 16'h1E10, 16'h01ED);
      wait_idle();

      // wide grid, with the receiver holding off while cells keep coming
      csr_write(casp_pkg::REG_GRID_WIDTH, 60);
      csr_write(casp_pkg::REG_GRID_HEIGHT, 0);
      csr_write(casp_pkg::REG_WALL_THRESHOLD, 8);
      csr_write(casp_pkg::REG_START_COL, 1023);
      csr_write(casp_pkg::REG_START_ROW, 1);
      csr_write(casp_pkg::REG_EXIT_COL, $urandom_range(1, 58));
      csr_write(casp_pkg::REG_EXIT_ROW, 1);
      void'(push_frame(1'b0));
      hold_off_armed <= 1'b1;
      wait_idle();

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         w = pick_dim();
         h = pick_dim();
         wc = clamp_dim(w, GRID_MAX_W);
         hc = clamp_dim(h, GRID_MAX_H);
         csr_write(casp_pkg::REG_GRID_WIDTH, w);
         csr_write(casp_pkg::REG_GRID_HEIGHT, h);
         csr_write(casp_pkg::REG_WALL_THRESHOLD,
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(3, 6));
         csr_write(casp_pkg::REG_START_COL, pick_coord(wc));
         csr_write(casp_pkg::REG_START_ROW, pick_coord(hc));
         csr_write(casp_pkg::REG_EXIT_COL, pick_coord(wc));
         csr_write(casp_pkg::REG_EXIT_ROW, pick_coord(hc));
         frames = $urandom_range(1, 3);
         repeat (frames) random_items += push_frame($urandom_range(0, 4) == 0);
         wait_idle();
      end

      // narrow tall grid via clamping, exit on the bottom border
      csr_write(casp_pkg::REG_GRID_WIDTH, 1);
      csr_write(casp_pkg::REG_GRID_HEIGHT, 60);
      csr_write(casp_pkg::REG_WALL_THRESHOLD, 15);
      csr_write(casp_pkg::REG_START_COL, 1);
      csr_write(casp_pkg::REG_START_ROW, $urandom_range(1, 58));
      csr_write(casp_pkg::REG_EXIT_COL, 1);
      csr_write(casp_pkg::REG_EXIT_ROW, 59);
      void'(push_frame(1'b1));
      wait_idle();

      if (mismatch_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire

### sim.f
+incdir+sv
sv/casp_pkg.sv
sv/cave_automaton_smoothing_pass_unit.sv
tb/cave_automaton_smoothing_pass_unit_tb.sv
